/* hw/rtl/hsfd_pkg.sv */
// ============================================================================
// hsfd_pkg
// Shared types and constants for the humidity sensor frame decoder.
// ============================================================================
`default_nettype none

package hsfd_pkg;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY_RESET = 8'h31;

    localparam logic KIND_MEASURE = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef enum logic [1:0] {
        RC_OK         = 2'd0,
        RC_FIRST_BAD  = 2'd1,
        RC_SECOND_BAD = 2'd2
    } result_code_t;

    // One completed frame, as handed from the frame tracker to the top level.
    typedef struct packed {
        logic         done;
        result_code_t code;
        logic         kind;
        logic [15:0]  first_word;
        logic [15:0]  second_word;
    } frame_result_t;

endpackage

`default_nettype wire

/* hw/rtl/hsfd_frame.sv */
// ============================================================================
// hsfd_frame
// Frame tracker: byte position, running CRC-8, held words and check flags.
// ============================================================================
`default_nettype none

module hsfd_frame (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   step,
    input  wire logic [7:0]             rx_byte,
    input  wire logic                   frame_start,
    input  wire logic                   frame_kind,
    input  wire logic [7:0]             crc_polynomial,
    output hsfd_pkg::frame_result_t     result
);
    import hsfd_pkg::*;

    localparam logic [2:0] POS_FIRST_HI  = 3'd0;
    localparam logic [2:0] POS_FIRST_LO  = 3'd1;
    localparam logic [2:0] POS_FIRST_CRC = 3'd2;
    localparam logic [2:0] POS_SECOND_HI = 3'd3;
    localparam logic [2:0] POS_SECOND_LO = 3'd4;

    logic [2:0]  pos_reg, pos_next;
    logic        active_reg, active_next;
    logic        kind_reg, kind_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] first_reg, first_next;
    logic [15:0] second_reg, second_next;
    logic        bad1_reg, bad1_next;

    logic        cur_active;
    logic [2:0]  cur_pos;
    logic [7:0]  cur_crc;
    logic        bad2;
    logic        done;

    // MSB-first CRC-8 over one byte, unrolled
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc,
                                             input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ poly;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    always_comb
    begin
        cur_active  = frame_start | active_reg;
        cur_pos     = frame_start ? POS_FIRST_HI : pos_reg;
        cur_crc     = frame_start ? CRC_INIT : crc_reg;
        kind_next   = frame_start ? frame_kind : kind_reg;
        first_next  = frame_start ? 16'h0000 : first_reg;
        second_next = frame_start ? 16'h0000 : second_reg;
        bad1_next   = frame_start ? 1'b0 : bad1_reg;
        crc_next    = cur_crc;
        pos_next    = pos_reg;
        active_next = active_reg;
        bad2        = 1'b0;
        done        = 1'b0;

        if (cur_active)
        begin
            unique case (cur_pos)
                POS_FIRST_HI:
                begin
                    first_next = {rx_byte, 8'h00};
                    crc_next   = crc8_byte(cur_crc, rx_byte, crc_polynomial);
                end
                POS_FIRST_LO:
                begin
                    first_next = {first_next[15:8], rx_byte};
                    crc_next   = crc8_byte(cur_crc, rx_byte, crc_polynomial);
                end
                POS_FIRST_CRC:
                begin
                    bad1_next = (rx_byte != cur_crc);
                    crc_next  = CRC_INIT;
                    done      = (kind_next == KIND_STATUS);
                end
                POS_SECOND_HI:
                begin
                    second_next = {rx_byte, 8'h00};
                    crc_next    = crc8_byte(cur_crc, rx_byte, crc_polynomial);
                end
                POS_SECOND_LO:
                begin
                    second_next = {second_next[15:8], rx_byte};
                    crc_next    = crc8_byte(cur_crc, rx_byte, crc_polynomial);
                end
                default:
                begin
                    bad2 = (rx_byte != cur_crc);
                    done = 1'b1;
                end
            endcase

            if (done)
            begin
                active_next = 1'b0;
                pos_next    = POS_FIRST_HI;
                crc_next    = CRC_INIT;
            end
            else
            begin
                active_next = 1'b1;
                pos_next    = cur_pos + 3'd1;
            end
        end
    end

    always_comb
    begin
        result.done        = done;
        result.kind        = kind_next;
        result.first_word  = first_next;
        result.second_word = (kind_next == KIND_STATUS) ? 16'h0000 : second_next;
        priority if (bad1_next)
            result.code = RC_FIRST_BAD;
        else if (bad2)
            result.code = RC_SECOND_BAD;
        else
            result.code = RC_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= POS_FIRST_HI;
            active_reg <= 1'b0;
            kind_reg   <= 1'b0;
            crc_reg    <= CRC_INIT;
            first_reg  <= 16'h0000;
            second_reg <= 16'h0000;
            bad1_reg   <= 1'b0;
        end
        else if (step)
        begin
            pos_reg    <= pos_next;
            active_reg <= active_next;
            kind_reg   <= kind_next;
            crc_reg    <= crc_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            bad1_reg   <= bad1_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/hsfd_convert.sv */
// ============================================================================
// hsfd_convert
// Raw word to hundredths of degree Celsius and of percent relative humidity.
// ============================================================================
`default_nettype none

module hsfd_convert (
    input  wire logic               kind,
    input  wire logic [15:0]        first_word,
    input  wire logic [15:0]        second_word,
    output logic signed [14:0]      temperature_centi,
    output logic [13:0]             humidity_centi
);
    import hsfd_pkg::*;

    localparam logic [14:0] TEMP_SPAN   = 15'd17500;
    localparam logic [13:0] HUM_SPAN    = 14'd10000;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;

    logic [30:0] t_prod;
    logic [31:0] t_sum;
    logic [14:0] t_quot;
    logic [29:0] h_prod;
    logic [30:0] h_sum;
    logic [13:0] h_quot;

    // x / 65535 = (x + (x >> 16) + 1) >> 16, exact while the quotient < 2^16
    always_comb
    begin
        t_prod = 31'(TEMP_SPAN) * 31'(first_word);
        t_sum  = 32'(t_prod) + 32'(t_prod[30:16]) + 32'd1;
        t_quot = t_sum[30:16];
        h_prod = 30'(HUM_SPAN) * 30'(second_word);
        h_sum  = 31'(h_prod) + 31'(h_prod[29:16]) + 31'd1;
        h_quot = h_sum[29:16];

        if (kind == KIND_STATUS)
        begin
            temperature_centi = 15'sd0;
            humidity_centi    = 14'd0;
        end
        else
        begin
            temperature_centi = $signed(t_quot - TEMP_OFFSET);
            humidity_centi    = h_quot;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/humidity_sensor_frame_decoder.sv */
// Timing: a frame-ending byte accepted into the input register has its result
// loaded into the output register as it leaves the input register; out_valid rises with that load.
// Throughput: one byte per cycle; the input register stalls only when it holds
// a frame-ending byte and the output register is full and stalled.
// Reset: asynchronous, active low; clears the pipeline, the frame tracker
// (no frame active, CRC 0xFF) and sets crc_polynomial to 0x31.
// ============================================================================
// humidity_sensor_frame_decoder
// Decodes measurement and status frames from a humidity/temperature sensor.
// ============================================================================
`default_nettype none

module humidity_sensor_frame_decoder (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write_en,
    input  wire logic [7:0]         cfg_write_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         rx_byte,
    input  wire logic               frame_start,
    input  wire logic               frame_kind,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              result_code,
    output logic                    kind_out,
    output logic [15:0]             first_word,
    output logic [15:0]             second_word,
    output logic signed [14:0]      temperature_centi,
    output logic [13:0]             humidity_centi
);
    import hsfd_pkg::*;

    logic [7:0]         poly_reg;

    logic               a_valid_reg, a_valid_next;
    logic [7:0]         a_byte_reg;
    logic               a_start_reg;
    logic               a_kind_reg;

    logic               out_valid_reg, out_valid_next;
    logic [1:0]         code_reg;
    logic               kind_reg;
    logic [15:0]        first_reg;
    logic [15:0]        second_reg;
    logic signed [14:0] temp_reg;
    logic [13:0]        hum_reg;

    frame_result_t      fr;
    logic signed [14:0] temp_val;
    logic [13:0]        hum_val;
    logic               out_free;
    logic               a_go;
    logic               in_take;
    logic               load_out;

    hsfd_frame u_frame (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (a_go),
        .rx_byte        (a_byte_reg),
        .frame_start    (a_start_reg),
        .frame_kind     (a_kind_reg),
        .crc_polynomial (poly_reg),
        .result         (fr)
    );

    hsfd_convert u_convert (
        .kind              (fr.kind),
        .first_word        (fr.first_word),
        .second_word       (fr.second_word),
        .temperature_centi (temp_val),
        .humidity_centi    (hum_val)
    );

    always_comb
    begin
        out_free       = !out_valid_reg || !out_stall;
        a_go           = a_valid_reg && (out_free || !fr.done);
        load_out       = a_go && fr.done;
        in_stall       = a_valid_reg && !a_go;
        in_take        = in_valid && !in_stall;
        a_valid_next   = in_take ? 1'b1 : (a_go ? 1'b0 : a_valid_reg);
        out_valid_next = load_out ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg      <= CRC_POLY_RESET;
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
                poly_reg <= cfg_write_data;
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            a_byte_reg  <= rx_byte;
            a_start_reg <= frame_start;
            a_kind_reg  <= frame_kind;
        end
        if (load_out)
        begin
            code_reg   <= fr.code;
            kind_reg   <= fr.kind;
            first_reg  <= fr.first_word;
            second_reg <= fr.second_word;
            temp_reg   <= temp_val;
            hum_reg    <= hum_val;
        end
    end

    assign out_valid         = out_valid_reg;
    assign result_code       = code_reg;
    assign kind_out          = kind_reg;
    assign first_word        = first_reg;
    assign second_word       = second_reg;
    assign temperature_centi = temp_reg;
    assign humidity_centi    = hum_reg;

endmodule

`default_nettype wire

/* hw/rtl/hsfd_checker.sv */
// ============================================================================
// hsfd_checker
// Port-level checks for the humidity sensor frame decoder, bound to the top.
// ============================================================================
`default_nettype none

module hsfd_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_stall,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic [1:0]         result_code,
    input  wire logic               kind_out,
    input  wire logic [15:0]        first_word,
    input  wire logic [15:0]        second_word,
    input  wire logic signed [14:0] temperature_centi,
    input  wire logic [13:0]        humidity_centi
);
    import hsfd_pkg::*;

    // a held result (first_word, result_code, humidity_centi) stays put until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(first_word)
            && $stable(result_code) && $stable(humidity_centi))
        else $error("result changed while stalled");

    // input backpressure only comes from a stalled full output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind_out == KIND_STATUS |-> second_word == 16'h0000
            && temperature_centi == 15'sd0 && humidity_centi == 14'd0)
        else $error("status frame carries measurement values");

    a_meas_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind_out == KIND_MEASURE |-> humidity_centi <= 14'd10000
            && temperature_centi >= -15'sd4500 && temperature_centi <= 15'sd13000)
        else $error("converted value out of range");

endmodule

bind humidity_sensor_frame_decoder hsfd_checker u_hsfd_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_stall          (in_stall),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .result_code       (result_code),
    .kind_out          (kind_out),
    .first_word        (first_word),
    .second_word       (second_word),
    .temperature_centi (temperature_centi),
    .humidity_centi    (humidity_centi)
);

`default_nettype wire

/* dv/tb.sv */
// ============================================================================
// tb
// Self-checking bench for humidity_sensor_frame_decoder: random and directed
// sensor bytes (good, corrupted, abandoned and stray frames) are checked
// against a cycle-free frame predictor over several CRC polynomial settings.
// ============================================================================
`default_nettype none

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import hsfd_pkg::*;

    localparam int unsigned TEMP_SPAN   = 17500;
    localparam int unsigned HUM_SPAN    = 10000;
    localparam int unsigned FULL_SCALE  = 65535;
    localparam int          TEMP_OFFSET = 4500;
    localparam logic [2:0]  POS_CRC_A   = 3'd2;
    localparam int          STALL_LIMIT = 3000;
    localparam int          LONG_HOLD   = 120;
    localparam int          HOLD_AT     = 30;

    typedef struct {
        logic [7:0] data;
        logic       start;
        logic       kind;
    } sensor_byte_t;

    typedef struct {
        result_code_t       code;
        logic               kind;
        logic [15:0]        w1;
        logic [15:0]        w2;
        logic signed [14:0] temp;
        logic [13:0]        hum;
    } frame_expect_t;

    logic clk;
    logic rst_n = 1'b0;
    logic cfg_write_en = 1'b0;
    logic [7:0] cfg_write_data = 8'h00;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [7:0] rx_byte = 8'h00;
    logic frame_start = 1'b0;
    logic frame_kind = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] result_code;
    logic kind_out;
    logic [15:0] first_word;
    logic [15:0] second_word;
    logic signed [14:0] temperature_centi;
    logic [13:0] humidity_centi;

    humidity_sensor_frame_decoder dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write_en      (cfg_write_en),
        .cfg_write_data    (cfg_write_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .rx_byte           (rx_byte),
        .frame_start       (frame_start),
        .frame_kind        (frame_kind),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .result_code       (result_code),
        .kind_out          (kind_out),
        .first_word        (first_word),
        .second_word       (second_word),
        .temperature_centi (temperature_centi),
        .humidity_centi    (humidity_centi)
    );

    sensor_byte_t  pending_bytes[$];
    frame_expect_t expected_frames[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int errors = 0;
    int bytes_sent = 0;
    int frames_checked = 0;
    int poly_settings = 1;
    int hold_left = 0;
    bit long_hold_done = 1'b0;
    int quiet_cycles = 0;

    // decoder shadow state
    logic [7:0]  crc_poly = CRC_POLY_RESET;
    logic [2:0]  frame_pos = 3'd0;
    logic        in_frame = 1'b0;
    logic        frame_kind_q = KIND_MEASURE;
    logic [7:0]  crc_run = CRC_INIT;
    logic [15:0] word_a = 16'h0000;
    logic [15:0] word_b = 16'h0000;
    logic        word_a_bad = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++)
            c = c[7] ? ((c << 1) ^ crc_poly) : (c << 1);
        return c;
    endfunction

    function automatic logic [7:0] word_crc(logic [15:0] w);
        return crc8_step(crc8_step(CRC_INIT, w[15:8]), w[7:0]);
    endfunction

    task automatic decode_byte(logic [7:0] data, logic start, logic kind);
        logic done;
        logic second_bad;
        frame_expect_t e;
        int unsigned scaled;
        done = 1'b0;
        second_bad = 1'b0;
        if (start)
        begin
            in_frame = 1'b1;
            frame_kind_q = kind;
            frame_pos = 3'd0;
            crc_run = CRC_INIT;
            word_a = 16'h0000;
            word_b = 16'h0000;
            word_a_bad = 1'b0;
        end
        if (in_frame)
        begin
            case (frame_pos)
                3'd0:
                begin
                    word_a = {data, 8'h00};
                    crc_run = crc8_step(crc_run, data);
                end
                3'd1:
                begin
                    word_a[7:0] = data;
                    crc_run = crc8_step(crc_run, data);
                end
                POS_CRC_A:
                begin
                    word_a_bad = (data != crc_run);
                    crc_run = CRC_INIT;
                    done = (frame_kind_q == KIND_STATUS);
                end
                3'd3:
                begin
                    word_b = {data, 8'h00};
                    crc_run = crc8_step(crc_run, data);
                end
                3'd4:
                begin
                    word_b[7:0] = data;
                    crc_run = crc8_step(crc_run, data);
                end
                default:
                begin
                    second_bad = (data != crc_run);
                    done = 1'b1;
                end
            endcase
            if (!done)
                frame_pos = frame_pos + 3'd1;
            else
            begin
                in_frame = 1'b0;
                frame_pos = 3'd0;
                crc_run = CRC_INIT;
                // first-word error takes priority
                e.code = word_a_bad ? RC_FIRST_BAD : (second_bad ? RC_SECOND_BAD : RC_OK);
                e.kind = frame_kind_q;
                e.w1 = word_a;
                if (frame_kind_q == KIND_STATUS)
                begin
                    e.w2 = 16'h0000;
                    e.temp = '0;
                    e.hum = '0;
                end
                else
                begin
                    e.w2 = word_b;
                    scaled = (TEMP_SPAN * word_a) / FULL_SCALE;
                    e.temp = 15'(int'(scaled) - TEMP_OFFSET);
                    scaled = (HUM_SPAN * word_b) / FULL_SCALE;
                    e.hum = 14'(scaled);
                end
                expected_frames.push_back(e);
            end
        end
    endtask

    task automatic cmp_field(string name, int want, int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic check_frame();
        frame_expect_t e;
        if (expected_frames.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result: expected none, actual first_word %h",
                     $time, first_word);
        end
        else
        begin
            e = expected_frames.pop_front();
            cmp_field("result_code", e.code, result_code);
            cmp_field("kind_out", e.kind, kind_out);
            cmp_field("first_word", e.w1, first_word);
            cmp_field("second_word", e.w2, second_word);
            cmp_field("temperature_centi", e.temp, temperature_centi);
            cmp_field("humidity_centi", e.hum, humidity_centi);
        end
        frames_checked++;
    endtask

    always @(posedge clk)
    begin : byte_driver
        sensor_byte_t nxt;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                decode_byte(rx_byte, frame_start, frame_kind);
                bytes_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    nxt = pending_bytes.pop_front();
                    in_valid <= 1'b1;
                    rx_byte <= nxt.data;
                    frame_start <= nxt.start;
                    frame_kind <= nxt.kind;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_frame();
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            // one long back-pressure stretch so the input side fills and stalls
            if (!long_hold_done && frames_checked == HOLD_AT)
            begin
                hold_left = LONG_HOLD;
                long_hold_done = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    task automatic push_byte(logic [7:0] data, logic start, logic kind);
        sensor_byte_t s;
        s.data = data;
        s.start = start;
        s.kind = kind;
        pending_bytes.push_back(s);
    endtask

    task automatic push_frame(logic kind, logic [15:0] w1, logic [15:0] w2, logic [1:0] bad);
        logic [7:0] flip_a;
        logic [7:0] flip_b;
        logic junk;
        flip_a = bad[0] ? 8'($urandom_range(1, 255)) : 8'd0;
        flip_b = bad[1] ? 8'($urandom_range(1, 255)) : 8'd0;
        junk = 1'($urandom);
        // frame_kind is only sampled on the start byte; the rest carry noise
        push_byte(w1[15:8], 1'b1, kind);
        push_byte(w1[7:0], 1'b0, junk);
        push_byte(word_crc(w1) ^ flip_a, 1'b0, ~junk);
        if (kind == KIND_MEASURE)
        begin
            push_byte(w2[15:8], 1'b0, 1'($urandom));
            push_byte(w2[7:0], 1'b0, 1'($urandom));
            push_byte(word_crc(w2) ^ flip_b, 1'b0, 1'($urandom));
        end
    endtask

    function automatic logic [15:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    task automatic push_random(int n);
        int target;
        int r;
        int len;
        logic [1:0] bad;
        target = pending_bytes.size() + n;
        while (pending_bytes.size() < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                bad = 2'b00;
                if ($urandom_range(0, 99) >= 70)
                    bad = 2'($urandom_range(1, 3));
                push_frame(1'($urandom), pick_word(), pick_word(), bad);
            end
            else if (r < 80)
            begin
                // frame cut short (unless a status one gets three bytes); later bytes or the next start byte end it
                len = $urandom_range(1, 5);
                push_byte(8'($urandom), 1'b1, 1'($urandom));
                for (int i = 1; i < len; i++)
                    push_byte(8'($urandom), 1'b0, 1'($urandom));
            end
            else if (r < 90)
            begin
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++)
                    push_byte(8'($urandom), 1'b0, 1'($urandom));
            end
            else
            begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                    push_byte(8'($urandom), 1'($urandom), 1'($urandom));
            end
        end
    endtask

    task automatic drain();
        while (pending_bytes.size() != 0 || in_valid || expected_frames.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_crc_poly(logic [7:0] poly);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= poly;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(negedge clk);
        crc_poly = poly;
        poly_settings++;
    endtask

    initial
    begin : stimulus
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 27;
        recv_idle_pct = 47;
        push_byte(8'hFF, 1'b0, KIND_STATUS);                     // stray byte, no frame open
        push_frame(KIND_MEASURE, 16'h0000, 16'hFFFF, 2'b00);     // scale extremes
        push_frame(KIND_MEASURE, 16'hFFFF, 16'h0000, 2'b11);     // both bad: first wins
        push_frame(KIND_MEASURE, 16'h6666, 16'h8000, 2'b10);     // second word bad
        push_byte(8'h12, 1'b1, KIND_MEASURE);                    // abandoned by next start
        push_byte(8'h34, 1'b0, KIND_STATUS);
        push_frame(KIND_STATUS, 16'hBEEF, 16'h0000, 2'b00);
        push_byte(8'h00, 1'b0, KIND_MEASURE);                    // trailing byte, ignored
        push_random(120);
        drain();

        set_crc_poly(8'hFF);
        send_idle_pct = 47;
        recv_idle_pct = 27;
        push_random(135);
        drain();

        set_crc_poly(8'h00);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_random(135);
        drain();

        set_crc_poly(8'($urandom_range(1, 254)));
        push_random(135);
        drain();

        repeat (6) @(negedge clk);
        if (expected_frames.size() != 0)
        begin
            errors += expected_frames.size();
            $display("%0t: %0d expected frames never arrived", $time, expected_frames.size());
        end
        $display("tb: %0d bytes in, %0d frames checked, %0d CRC polynomial settings",
                 bytes_sent, frames_checked, poly_settings);
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
